/* hw/rtl/serial_frame_receiver_value_decoder_macros.svh */
// Assertion macros shared by the frame receiver RTL.
// Uses the module's clk and rst; expands to nothing under SYNTHESIS.
`ifndef SERIAL_FRAME_RECEIVER_VALUE_DECODER_MACROS_SVH
`define SERIAL_FRAME_RECEIVER_VALUE_DECODER_MACROS_SVH
`ifndef SYNTHESIS
`define SFRVD_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("sfrvd assertion failed");
`define SFRVD_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("sfrvd assertion failed");
`else
`define SFRVD_ASSERT(name, prop)
`define SFRVD_ASSERT_ALWAYS(name, prop)
`endif
`endif

/* hw/rtl/sfrvd_pkg.sv */
// Types and constants for the serial frame receiver and value decoder.
// No dependencies.
`default_nettype none
package sfrvd_pkg;

  localparam logic [7:0] HEADER_BYTE = 8'hFE;
  localparam logic [7:0] KIND_RAW    = 8'h80;
  localparam logic [7:0] KIND_WORD   = 8'h81;
  localparam logic [7:0] KIND_SIGNED = 8'h82;
  localparam logic [7:0] MAG_MASK    = 8'h7F;

  // x / 100 == (x * 83887) >> 23 for every x below 2**16
  localparam logic [16:0] RECIP_100   = 17'd83887;
  localparam int          RECIP_SHIFT = 23;

  localparam logic REG_DEVICE_ID = 1'b0;

  typedef enum logic [1:0] {
    ST_DECODED     = 2'd0,
    ST_BAD_SUM     = 2'd1,
    ST_OTHER_ADDR  = 2'd2,
    ST_UNDECODABLE = 2'd3
  } status_t;

  typedef struct packed {
    logic            done;
    logic            sum_ok;
    logic [7:0]      kind;
    logic [7:0]      address;
    logic [7:0]      length;
    logic [3:0][7:0] payload;
  } frame_t;

endpackage
`default_nettype wire

/* hw/rtl/sfrvd_parser.sv */
// Frame parser: header hunt, field capture, running checksum.
// Depends on sfrvd_pkg.
`default_nettype none
module sfrvd_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        byte_in,
  output sfrvd_pkg::frame_t frame
);
  import sfrvd_pkg::*;

  logic [8:0]      byte_index;
  logic [7:0]      kind;
  logic [7:0]      address;
  logic [7:0]      length;
  logic [7:0]      running_sum;
  logic [3:0][7:0] payload;
  logic            at_end;

  assign at_end = (byte_index >= 9'd4) && (byte_index == ({1'b0, length} + 9'd4));

  always_comb begin
    frame.done    = step && at_end;
    frame.sum_ok  = (byte_in == running_sum);
    frame.kind    = kind;
    frame.address = address;
    frame.length  = length;
    frame.payload = payload;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index  <= '0;
      kind        <= '0;
      address     <= '0;
      length      <= '0;
      running_sum <= '0;
    end else if (step) begin
      priority if (byte_index == 9'd0) begin
        if (byte_in == HEADER_BYTE) begin
          running_sum <= byte_in;
          byte_index  <= 9'd1;
        end
      end else if (at_end) begin
        byte_index <= '0;
      end else begin
        if (byte_index == 9'd1) kind    <= byte_in;
        if (byte_index == 9'd2) address <= byte_in;
        if (byte_index == 9'd3) length  <= byte_in;
        running_sum <= running_sum + byte_in;
        byte_index  <= byte_index + 9'd1;
      end
    end
  end

  // first four payload bytes only
  always_ff @(posedge clk) begin
    if (step && !at_end && byte_index >= 9'd4 && byte_index <= 9'd7) begin
      payload[byte_index[1:0]] <= byte_in;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/sfrvd_decoder.sv */
// Value decoder: status selection and scaled value decode of a finished frame.
// Depends on sfrvd_pkg.
`default_nettype none
module sfrvd_decoder (
  input  logic                     [7:0] device_id,
  input  sfrvd_pkg::frame_t              frame,
  input  logic signed             [10:0] held_first,
  input  logic signed              [9:0] held_second,
  output sfrvd_pkg::status_t             status,
  output logic signed             [10:0] first_next,
  output logic signed              [9:0] second_next
);
  import sfrvd_pkg::*;

  logic [15:0]        mag0;
  logic [15:0]        mag1;
  logic [32:0]        prod0;
  logic [32:0]        prod1;
  logic [9:0]         quot0;
  logic [9:0]         quot1;
  logic signed [10:0] q0s;
  logic signed [10:0] q1s;
  logic signed [10:0] sm0;
  logic signed [10:0] sm1;

  always_comb begin
    if (frame.kind == KIND_WORD) begin
      mag0 = {frame.payload[0], frame.payload[1]};
    end else begin
      mag0 = {frame.payload[0] & MAG_MASK, frame.payload[1]};
    end
    mag1  = {frame.payload[2] & MAG_MASK, frame.payload[3]};
    prod0 = {17'd0, mag0} * {16'd0, RECIP_100};
    prod1 = {17'd0, mag1} * {16'd0, RECIP_100};
    quot0 = prod0[RECIP_SHIFT +: 10];
    quot1 = prod1[RECIP_SHIFT +: 10];
    q0s   = signed'({1'b0, quot0});
    q1s   = signed'({1'b0, quot1});
    sm0   = frame.payload[0][7] ? -q0s : q0s;
    sm1   = frame.payload[2][7] ? -q1s : q1s;
  end

  always_comb begin
    status      = ST_UNDECODABLE;
    first_next  = held_first;
    second_next = held_second;
    priority if (!frame.sum_ok) begin
      status = ST_BAD_SUM;
    end else if (frame.address != device_id) begin
      status = ST_OTHER_ADDR;
    end else if (frame.kind == KIND_RAW && frame.length >= 8'd1) begin
      status     = ST_DECODED;
      first_next = signed'({3'd0, frame.payload[0]});
    end else if (frame.kind == KIND_WORD && frame.length >= 8'd2) begin
      status     = ST_DECODED;
      first_next = q0s;
    end else if (frame.kind == KIND_SIGNED &&
                 (frame.length == 8'd2 || frame.length == 8'd4)) begin
      status     = ST_DECODED;
      first_next = sm0;
      if (frame.length == 8'd4) second_next = sm1[9:0];
    end else begin
      status = ST_UNDECODABLE;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/serial_frame_receiver_value_decoder.sv */
// Top level: serial frame receiver and value decoder with APB config port.
// Depends on sfrvd_pkg, sfrvd_parser, sfrvd_decoder and the macros header.
//
//   channel  signals                                         word
//   rx       rx_valid / rx_stall                             rx_byte
//   res      res_valid / res_stall                           status, frame_type,
//                                                            first_value, second_value
//   cfg      psel penable pwrite paddr pwdata prdata pready  device_id at 0x0
//
// One byte per cycle while rx_stall is low: input register, then parse and decode into the result register.
// The result word is registered once its checksum byte has passed the input register and been parsed.
// rst is synchronous; clears control state, held values and device_id.
// rx_stall rises only while a byte is waiting and the result register is stalled.
`default_nettype none
`include "serial_frame_receiver_value_decoder_macros.svh"
module serial_frame_receiver_value_decoder (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       rx_valid,
  output logic                       rx_stall,
  input  logic                 [7:0] rx_byte,
  output logic                       res_valid,
  input  logic                       res_stall,
  output sfrvd_pkg::status_t         status,
  output logic                 [7:0] frame_type,
  output logic signed         [10:0] first_value,
  output logic signed          [9:0] second_value,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic                 [2:0] paddr,
  input  logic                [31:0] pwdata,
  output logic                [31:0] prdata,
  output logic                       pready
);
  import sfrvd_pkg::*;

  logic               s1_valid;
  logic [7:0]         byte_q;
  logic               out_free;
  logic               proc;
  logic [7:0]         device_id;
  logic signed [10:0] held_first;
  logic signed [9:0]  held_second;
  logic signed [10:0] first_next;
  logic signed [9:0]  second_next;
  frame_t             frame;
  status_t            status_next;

  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == REG_DEVICE_ID) ? {24'd0, device_id} : 32'd0;
  assign out_free = !res_valid || !res_stall;
  assign proc     = s1_valid && out_free;
  assign rx_stall = s1_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_id <= '0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_DEVICE_ID) begin
      device_id <= pwdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!rx_stall) begin
      s1_valid <= rx_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rx_stall) byte_q <= rx_byte;
  end

  sfrvd_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (proc),
    .byte_in (byte_q),
    .frame   (frame)
  );

  sfrvd_decoder u_decoder (
    .device_id   (device_id),
    .frame       (frame),
    .held_first  (held_first),
    .held_second (held_second),
    .status      (status_next),
    .first_next  (first_next),
    .second_next (second_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      held_first  <= '0;
      held_second <= '0;
      res_valid   <= 1'b0;
    end else if (frame.done) begin
      held_first  <= first_next;
      held_second <= second_next;
      res_valid   <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame.done) begin
      status       <= status_next;
      frame_type   <= frame.kind;
      first_value  <= first_next;
      second_value <= second_next;
    end
  end

  `SFRVD_ASSERT(a_stall_needs_word, rx_stall |-> s1_valid && res_valid)
  `SFRVD_ASSERT(a_done_gives_result, frame.done |=> res_valid)
  `SFRVD_ASSERT(a_held_only_on_decode,
    !(frame.done && status_next == ST_DECODED) |=>
      $stable(held_first) && $stable(held_second))
  `SFRVD_ASSERT_ALWAYS(a_ready_high, pready)

endmodule
`default_nettype wire

/* sim/tb_top.sv */
`timescale 1ns / 100ps
// Testbench for serial_frame_receiver_value_decoder: random and directed frames,
// checked against an in-bench frame decoder. Depends on sfrvd_pkg and the RTL.
module tb_top;
  import sfrvd_pkg::*;

  localparam logic [2:0]  ADDR_DEVICE_ID = 3'(4 * int'(REG_DEVICE_ID));
  localparam logic [7:0]  SIGN_BIT       = 8'h80;
  localparam int unsigned DIV_SCALE      = 100;
  localparam int          DRAIN_CYCLES   = 8;
  localparam int          CYCLE_LIMIT    = 400000;

  typedef struct {
    status_t            status;
    logic        [7:0]  frame_type;
    logic signed [10:0] first_value;
    logic signed [9:0]  second_value;
  } frame_report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        rx_valid = 1'b0;
  logic        rx_stall;
  logic [7:0]  rx_byte = 8'h00;
  logic        res_valid;
  logic        res_stall = 1'b0;
  status_t     status;
  logic [7:0]  frame_type;
  logic signed [10:0] first_value;
  logic signed [9:0]  second_value;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  serial_frame_receiver_value_decoder DUT (
    .clk, .rst,
    .rx_valid, .rx_stall, .rx_byte,
    .res_valid, .res_stall, .status, .frame_type, .first_value, .second_value,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // decoder state mirror
  logic [7:0]         dev_id = 8'h00;
  logic [8:0]         byte_pos = 9'd0;
  logic [7:0]         frm_kind = 8'h00;
  logic [7:0]         frm_addr = 8'h00;
  logic [7:0]         frm_len = 8'h00;
  logic [7:0]         frm_head [4] = '{default: 8'h00};
  logic [7:0]         frm_sum = 8'h00;
  logic signed [10:0] held_x = '0;
  logic signed [9:0]  held_y = '0;

  frame_report_t frame_reports[$];
  logic [7:0]    rx_bytes_todo[$];
  int            tx_idle_pct = 0;
  int            rx_stall_pct = 0;
  int            fails = 0;
  int            cycles = 0;
  int            words_queued = 0;

  function automatic logic signed [10:0] sign_mag_div(logic [7:0] hi, logic [7:0] lo);
    logic [14:0] mag;
    logic [10:0] q;
    mag = {7'(hi & MAG_MASK), lo};
    q = 11'(mag / DIV_SCALE);
    return ((hi & SIGN_BIT) != 8'h00) ? -q : q;
  endfunction

  task automatic decode_rx_byte(input logic [7:0] b);
    frame_report_t r;
    if (byte_pos == 9'd0) begin
      if (b == HEADER_BYTE) begin
        frm_sum = b;
        byte_pos = 9'd1;
      end
    end else if (byte_pos >= 9'd4 && byte_pos == {1'b0, frm_len} + 9'd4) begin
      if (b != frm_sum) begin
        r.status = ST_BAD_SUM;
      end else if (frm_addr != dev_id) begin
        r.status = ST_OTHER_ADDR;
      end else if (frm_kind == KIND_RAW && frm_len >= 8'd1) begin
        held_x = {3'b000, frm_head[0]};
        r.status = ST_DECODED;
      end else if (frm_kind == KIND_WORD && frm_len >= 8'd2) begin
        held_x = 11'({frm_head[0], frm_head[1]} / DIV_SCALE);
        r.status = ST_DECODED;
      end else if (frm_kind == KIND_SIGNED && (frm_len == 8'd2 || frm_len == 8'd4)) begin
        held_x = sign_mag_div(frm_head[0], frm_head[1]);
        if (frm_len == 8'd4) held_y = 10'(sign_mag_div(frm_head[2], frm_head[3]));
        r.status = ST_DECODED;
      end else begin
        r.status = ST_UNDECODABLE;
      end
      r.frame_type = frm_kind;
      r.first_value = held_x;
      r.second_value = held_y;
      frame_reports.push_back(r);
      byte_pos = 9'd0;
    end else begin
      case (byte_pos)
        9'd1: frm_kind = b;
        9'd2: frm_addr = b;
        9'd3: frm_len = b;
        default: if (byte_pos <= 9'd7) frm_head[byte_pos[1:0]] = b;
      endcase
      frm_sum = frm_sum + b;
      byte_pos = byte_pos + 9'd1;
    end
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      rx_valid <= 1'b0;
    end else begin
      if (rx_valid && !rx_stall) decode_rx_byte(rx_byte);
      if (!rx_valid || !rx_stall) begin
        if (rx_bytes_todo.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
          rx_valid <= 1'b1;
          rx_byte <= rx_bytes_todo.pop_front();
        end else begin
          rx_valid <= 1'b0;
        end
      end
    end
  end

  // result receiver and checker
  always @(posedge clk) begin : result_check
    frame_report_t want;
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        if (frame_reports.size() == 0) begin
          $error("unexpected result word: status %0d type %0h", status, frame_type);
          fails++;
        end else begin
          want = frame_reports.pop_front();
          if (status != want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            fails++;
          end
          if (frame_type != want.frame_type) begin
            $error("frame_type: expected %0h, got %0h", want.frame_type, frame_type);
            fails++;
          end
          if (first_value != want.first_value) begin
            $error("first_value: expected %0d, got %0d", want.first_value, first_value);
            fails++;
          end
          if (second_value != want.second_value) begin
            $error("second_value: expected %0d, got %0d", want.second_value, second_value);
            fails++;
          end
        end
      end
      res_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic add_frame(input logic [7:0] kind, input logic [7:0] addr,
                           input logic [7:0] len, input logic [31:0] head,
                           input bit bad_sum);
    logic [7:0] s;
    logic [7:0] b;
    s = HEADER_BYTE + kind + addr + len;
    rx_bytes_todo.push_back(HEADER_BYTE);
    rx_bytes_todo.push_back(kind);
    rx_bytes_todo.push_back(addr);
    rx_bytes_todo.push_back(len);
    for (int i = 0; i < int'(len); i++) begin
      b = (i < 4) ? head[31 - 8 * i -: 8] : 8'($urandom);
      rx_bytes_todo.push_back(b);
      s = s + b;
    end
    if (bad_sum) s = s + 8'($urandom_range(1, 255));
    rx_bytes_todo.push_back(s);
    words_queued += int'(len) + 5;
  endtask

  task automatic add_noise(input int n);
    logic [7:0] b;
    repeat (n) begin
      b = 8'($urandom);
      if (b == HEADER_BYTE) b = 8'h00;
      rx_bytes_todo.push_back(b);
    end
    words_queued += n;
  endtask

  task automatic add_random_traffic(input int n_words);
    int target;
    int pick;
    logic [7:0] kind;
    logic [7:0] len;
    logic [7:0] addr;
    target = words_queued + n_words;
    while (words_queued < target) begin
      pick = $urandom_range(99);
      if (pick < 82) begin
        case ($urandom_range(3))
          0: kind = KIND_RAW;
          1: kind = KIND_WORD;
          2: kind = KIND_SIGNED;
          default: kind = 8'($urandom);
        endcase
        len = 8'($urandom_range(0, 5));
        if (kind == KIND_SIGNED && $urandom_range(3) != 0)
          len = ($urandom_range(1) != 0) ? 8'd4 : 8'd2;
        if ($urandom_range(49) == 0) len = 8'($urandom_range(6, 255));
        addr = ($urandom_range(3) != 0) ? dev_id : 8'($urandom);
        add_frame(kind, addr, len, $urandom, $urandom_range(11) == 0);
      end else if (pick < 92) begin
        add_noise($urandom_range(1, 4));
      end else begin
        // cut-off frame: following bytes get absorbed into it
        rx_bytes_todo.push_back(HEADER_BYTE);
        pick = $urandom_range(1, 6);
        repeat (pick) rx_bytes_todo.push_back(8'($urandom));
        words_queued += pick + 1;
      end
    end
  endtask

  task automatic drain();
    while (rx_bytes_todo.size() != 0 || rx_valid) @(posedge clk);
    while (frame_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_device_id(input logic [7:0] v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_DEVICE_ID;
    pwdata <= {24'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    dev_id = v;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    tx_idle_pct = 33;
    rx_stall_pct = 56;
    write_device_id(8'h00);
    rx_bytes_todo.push_back(8'h00);
    rx_bytes_todo.push_back(8'h7F);
    rx_bytes_todo.push_back(8'hFF);
    add_frame(KIND_RAW, 8'h00, 8'd1, 32'hFF000000, 0);
    add_frame(KIND_RAW, 8'h00, 8'd0, 32'h0, 0);
    add_frame(KIND_WORD, 8'h00, 8'd2, 32'hFFFF0000, 0);
    add_frame(KIND_WORD, 8'h00, 8'd1, 32'h12000000, 0);
    add_frame(KIND_WORD, 8'h00, 8'd3, 32'h00000000, 0);
    add_frame(KIND_SIGNED, 8'h00, 8'd4, 32'hFFFF7FFF, 0);
    add_frame(KIND_SIGNED, 8'h00, 8'd2, 32'h80630000, 0);
    add_frame(KIND_SIGNED, 8'h00, 8'd3, 32'h01020304, 0);
    add_frame(KIND_SIGNED, 8'h00, 8'd0, 32'h0, 0);
    add_frame(8'h00, 8'h00, 8'd2, 32'h55AA0000, 0);
    add_frame(HEADER_BYTE, 8'h00, 8'd4, 32'hFEFEFEFE, 0);
    add_frame(KIND_RAW, 8'h01, 8'd1, 32'h33000000, 0);
    add_frame(KIND_RAW, 8'h00, 8'd1, 32'h44000000, 1);
    add_frame(KIND_RAW, 8'h55, 8'd1, 32'h44000000, 1);
    add_frame(8'hFF, 8'hFF, 8'hFF, 32'h01020304, 0);
    add_frame(KIND_RAW, 8'h00, 8'd255, 32'hAB020304, 0);
    drain();

    write_device_id(8'hFF);
    add_random_traffic(400);
    drain();

    tx_idle_pct = 56;
    rx_stall_pct = 33;
    write_device_id(8'($urandom));
    add_random_traffic(400);
    drain();

    tx_idle_pct = 0;
    rx_stall_pct = 0;
    write_device_id(8'($urandom));
    add_random_traffic(400);
    drain();

    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/sfrvd_pkg.sv
hw/rtl/sfrvd_parser.sv
hw/rtl/sfrvd_decoder.sv
hw/rtl/serial_frame_receiver_value_decoder.sv
sim/tb_top.sv
